// File: design/pid_integral_clamp_band_reset_unit_defines.svh
// Assertion macros for the PID integral clamp / band reset unit.
// Included by the checker; no other dependencies.
`ifndef PID_INTEGRAL_CLAMP_BAND_RESET_UNIT_DEFINES_SVH
`define PID_INTEGRAL_CLAMP_BAND_RESET_UNIT_DEFINES_SVH

// same-cycle implication, disabled while reset is high
`define PIDCB_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled while reset is high
`define PIDCB_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/pidcb_pkg.sv
// Shared constants for the PID integral clamp / band reset unit.
// No dependencies; used by the top level and its checker.
package pidcb_pkg;

   // field widths
   localparam int ANGLE_W   = 16;
   localparam int DT_W      = 16;
   localparam int GAIN_W    = 16;
   localparam int LIMIT_W   = 39;
   localparam int BAND_W    = 15;
   localparam int DRIVE_W   = 16;
   localparam int ERR_W     = 17;
   localparam int SUM_W     = 40;
   localparam int DERIV_W   = 32;
   localparam int FRAC_SH   = 20;
   localparam int OUT_SH    = 16;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = LIMIT_W;

   localparam logic [CSR_IDX_W-1:0] REG_SETPOINT  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_P    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_I    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_GAIN_D    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_INT_LIMIT = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_BAND      = 3'd5;

   // register reset values
   localparam logic [ANGLE_W-1:0] SETPOINT_RST  = 16'd0;
   localparam logic [GAIN_W-1:0]  GAIN_P_RST    = 16'd3840;
   localparam logic [GAIN_W-1:0]  GAIN_I_RST    = 16'd0;
   localparam logic [GAIN_W-1:0]  GAIN_D_RST    = 16'd256;
   localparam logic [LIMIT_W-1:0] INT_LIMIT_RST = 39'd26843545600;
   localparam logic [BAND_W-1:0]  BAND_RST      = 15'd256;

   // divider: |diff| is 18 bits, shifted left by the fraction width
   localparam int DVD_W     = ERR_W + 1 + FRAC_SH;
   localparam int DIV_STEPS = DVD_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   // shared multiplier operand widths
   localparam int MUL_A_W = GAIN_W + 1;
   localparam int MUL_B_W = DERIV_W + 1;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;
   localparam int ACC_W   = PROD_W + 1;

   localparam logic [DRIVE_W-1:0] DRIVE_MAX = 16'h7FFF;
   localparam logic [DRIVE_W-1:0] DRIVE_MIN = 16'h8000;
   localparam logic [DERIV_W-1:0] DERIV_MAX = 32'h7FFF_FFFF;
   localparam logic [DERIV_W-1:0] DERIV_MIN = 32'h8000_0000;

endpackage

// File: design/pid_integral_clamp_band_reset_unit.sv
// Top level of the PID integral clamp / band reset unit: sequencer, shared
// 17x33 multiplier and a one-bit-per-cycle restoring divider.
// Depends on pidcb_pkg.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_stall  req_angle, req_step_time
//   rsp      out        rsp_valid / rsp_stall  rsp_drive, rsp_saturated
//   csr      in         csr_valid / csr_ready  csr_index, csr_data
//
// Each sample runs from acceptance through the derivative divider (one quotient
// bit per cycle), four passes through the shared multiplier plus sum, clamp and
// output steps; the next sample is accepted only once the sequencer is idle again.
// The result sits in an output register; the next sample is accepted while it
// waits, and the sequencer holds in its output step only if it is still stalled.
// Synchronous active-high reset inits controller states, sequencer, valid and config.
module pid_integral_clamp_band_reset_unit (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [pidcb_pkg::ANGLE_W-1:0]  req_angle,
   input  logic [pidcb_pkg::DT_W-1:0]            req_step_time,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [pidcb_pkg::DRIVE_W-1:0]  rsp_drive,
   output logic                                  rsp_saturated,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [pidcb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pidcb_pkg::CSR_DATA_W-1:0]      csr_data
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_E,
      ST_SUM,
      ST_CLAMP,
      ST_DIV,
      ST_SAT,
      ST_MUL_P,
      ST_MUL_I,
      ST_MUL_D,
      ST_ACC,
      ST_OUT
   } state_type;

   state_type state_ff, state_in;

   // configuration
   logic [pidcb_pkg::ANGLE_W-1:0] setpoint_ff, setpoint_in;
   logic [pidcb_pkg::GAIN_W-1:0]  gain_p_ff, gain_p_in;
   logic [pidcb_pkg::GAIN_W-1:0]  gain_i_ff, gain_i_in;
   logic [pidcb_pkg::GAIN_W-1:0]  gain_d_ff, gain_d_in;
   logic [pidcb_pkg::LIMIT_W-1:0] limit_ff, limit_in;
   logic [pidcb_pkg::BAND_W-1:0]  band_ff, band_in;

   // controller state
   logic [pidcb_pkg::ERR_W-1:0]   last_error_ff, last_error_in;
   logic [pidcb_pkg::SUM_W-1:0]   error_sum_ff, error_sum_in;

   // per-sample working registers
   logic [pidcb_pkg::ERR_W-1:0]   err_ff, err_in;
   logic [pidcb_pkg::DT_W-1:0]    dt_ff, dt_in;
   logic [pidcb_pkg::DT_W-1:0]    divisor_ff, divisor_in;
   logic [pidcb_pkg::DT_W-1:0]    rem_ff, rem_in;
   logic [pidcb_pkg::DVD_W-1:0]   dvd_ff, dvd_in;
   logic [pidcb_pkg::CNT_W-1:0]   cnt_ff, cnt_in;
   logic                          neg_ff, neg_in;
   logic [pidcb_pkg::SUM_W:0]     sum_ff, sum_in;
   logic                          band_hit_ff, band_hit_in;
   logic [pidcb_pkg::DERIV_W-1:0] deriv_ff, deriv_in;
   logic [pidcb_pkg::PROD_W-1:0]  prod_ff, prod_in;
   logic [pidcb_pkg::ACC_W-1:0]   acc_ff, acc_in;

   // result register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [pidcb_pkg::DRIVE_W-1:0] drive_ff, drive_in;
   logic                          sat_ff, sat_in;

   // shared multiplier
   logic signed [pidcb_pkg::MUL_A_W-1:0] mul_a;
   logic signed [pidcb_pkg::MUL_B_W-1:0] mul_b;
   logic signed [pidcb_pkg::PROD_W-1:0]  mul_prod;

   logic                          req_acc;
   logic [pidcb_pkg::ERR_W-1:0]   err_new;
   logic [pidcb_pkg::ERR_W:0]     diff;
   logic [pidcb_pkg::ERR_W:0]     diff_mag;
   logic [pidcb_pkg::ERR_W-1:0]   err_mag;
   logic [pidcb_pkg::SUM_W:0]     lim_pos;
   logic [pidcb_pkg::SUM_W:0]     lim_neg;
   logic [pidcb_pkg::DT_W:0]      trial;
   logic                          trial_ge;
   logic [pidcb_pkg::DVD_W-1:0]   quo_neg;
   logic [pidcb_pkg::ACC_W-pidcb_pkg::OUT_SH-1:0] shifted;

   assign req_stall     = (state_ff != ST_IDLE);
   assign req_acc       = req_valid && !req_stall;
   assign csr_ready     = 1'b1;
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_drive     = drive_ff;
   assign rsp_saturated = sat_ff;

   assign err_new  = {setpoint_ff[pidcb_pkg::ANGLE_W-1], setpoint_ff}
                   - {req_angle[pidcb_pkg::ANGLE_W-1], req_angle};
   assign diff     = {err_new[pidcb_pkg::ERR_W-1], err_new}
                   - {last_error_ff[pidcb_pkg::ERR_W-1], last_error_ff};
   assign diff_mag = diff[pidcb_pkg::ERR_W] ? -diff : diff;
   assign err_mag  = err_ff[pidcb_pkg::ERR_W-1] ? -err_ff : err_ff;

   assign lim_pos  = {2'b00, limit_ff};
   assign lim_neg  = -lim_pos;

   assign trial    = {rem_ff, dvd_ff[pidcb_pkg::DVD_W-1]};
   assign trial_ge = (trial >= {1'b0, divisor_ff});
   assign quo_neg  = -dvd_ff;
   assign shifted  = acc_ff[pidcb_pkg::ACC_W-1:pidcb_pkg::OUT_SH];

   always_comb begin
      case (state_ff)
         ST_MUL_P: begin
            mul_a = {1'b0, gain_p_ff};
            mul_b = {{(pidcb_pkg::MUL_B_W-pidcb_pkg::ERR_W){err_ff[pidcb_pkg::ERR_W-1]}},
                     err_ff};
         end
         ST_MUL_I: begin
            mul_a = {1'b0, gain_i_ff};
            mul_b = {{(pidcb_pkg::MUL_B_W-pidcb_pkg::SUM_W+pidcb_pkg::FRAC_SH)
                      {error_sum_ff[pidcb_pkg::SUM_W-1]}},
                     error_sum_ff[pidcb_pkg::SUM_W-1:pidcb_pkg::FRAC_SH]};
         end
         ST_MUL_D: begin
            mul_a = {1'b0, gain_d_ff};
            mul_b = {deriv_ff[pidcb_pkg::DERIV_W-1], deriv_ff};
         end
         default: begin
            mul_a = {1'b0, dt_ff};
            mul_b = {{(pidcb_pkg::MUL_B_W-pidcb_pkg::ERR_W){err_ff[pidcb_pkg::ERR_W-1]}},
                     err_ff};
         end
      endcase
   end

   assign mul_prod = pidcb_pkg::PROD_W'(mul_a) * pidcb_pkg::PROD_W'(mul_b);

   always_comb begin
      state_in      = state_ff;
      setpoint_in   = setpoint_ff;
      gain_p_in     = gain_p_ff;
      gain_i_in     = gain_i_ff;
      gain_d_in     = gain_d_ff;
      limit_in      = limit_ff;
      band_in       = band_ff;
      last_error_in = last_error_ff;
      error_sum_in  = error_sum_ff;
      err_in        = err_ff;
      dt_in         = dt_ff;
      divisor_in    = divisor_ff;
      rem_in        = rem_ff;
      dvd_in        = dvd_ff;
      cnt_in        = cnt_ff;
      neg_in        = neg_ff;
      sum_in        = sum_ff;
      band_hit_in   = band_hit_ff;
      deriv_in      = deriv_ff;
      prod_in       = prod_ff;
      acc_in        = acc_ff;
      drive_in      = drive_ff;
      sat_in        = sat_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            pidcb_pkg::REG_SETPOINT:  setpoint_in = csr_data[pidcb_pkg::ANGLE_W-1:0];
            pidcb_pkg::REG_GAIN_P:    gain_p_in   = csr_data[pidcb_pkg::GAIN_W-1:0];
            pidcb_pkg::REG_GAIN_I:    gain_i_in   = csr_data[pidcb_pkg::GAIN_W-1:0];
            pidcb_pkg::REG_GAIN_D:    gain_d_in   = csr_data[pidcb_pkg::GAIN_W-1:0];
            pidcb_pkg::REG_INT_LIMIT: limit_in    = csr_data[pidcb_pkg::LIMIT_W-1:0];
            pidcb_pkg::REG_BAND:      band_in     = csr_data[pidcb_pkg::BAND_W-1:0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_acc) begin
               err_in        = err_new;
               dt_in         = req_step_time;
               // zero step time divides by one
               divisor_in    = (req_step_time == '0) ? pidcb_pkg::DT_W'(1) : req_step_time;
               neg_in        = diff[pidcb_pkg::ERR_W];
               dvd_in        = {diff_mag, {pidcb_pkg::FRAC_SH{1'b0}}};
               rem_in        = '0;
               cnt_in        = '0;
               last_error_in = err_new;
               state_in      = ST_MUL_E;
            end
         end
         ST_MUL_E: begin
            prod_in  = mul_prod;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            // err*dt fits 33 bits, so the low bits of the product carry its sign
            sum_in      = {error_sum_ff[pidcb_pkg::SUM_W-1], error_sum_ff}
                        + prod_ff[pidcb_pkg::SUM_W:0];
            band_hit_in = ({1'b0, err_mag} <= {3'b000, band_ff});
            state_in    = ST_CLAMP;
         end
         ST_CLAMP: begin
            if (band_hit_ff) begin
               error_sum_in = '0;
            end else if ($signed(sum_ff) > $signed(lim_pos)) begin
               error_sum_in = lim_pos[pidcb_pkg::SUM_W-1:0];
            end else if ($signed(sum_ff) < $signed(lim_neg)) begin
               error_sum_in = lim_neg[pidcb_pkg::SUM_W-1:0];
            end else begin
               error_sum_in = sum_ff[pidcb_pkg::SUM_W-1:0];
            end
            state_in = ST_DIV;
         end
         ST_DIV: begin
            // restoring division, quotient bits shift in where dividend bits leave
            rem_in = trial_ge ? pidcb_pkg::DT_W'(trial - {1'b0, divisor_ff})
                              : trial[pidcb_pkg::DT_W-1:0];
            dvd_in = {dvd_ff[pidcb_pkg::DVD_W-2:0], trial_ge};
            cnt_in = cnt_ff + pidcb_pkg::CNT_W'(1);
            if (cnt_ff == pidcb_pkg::CNT_W'(pidcb_pkg::DIV_STEPS - 1)) begin
               state_in = ST_SAT;
            end
         end
         ST_SAT: begin
            if (!neg_ff) begin
               deriv_in = (dvd_ff > {6'b0, pidcb_pkg::DERIV_MAX}) ? pidcb_pkg::DERIV_MAX
                                                                  : dvd_ff[pidcb_pkg::DERIV_W-1:0];
            end else begin
               deriv_in = (dvd_ff > {6'b0, pidcb_pkg::DERIV_MIN}) ? pidcb_pkg::DERIV_MIN
                                                                  : quo_neg[pidcb_pkg::DERIV_W-1:0];
            end
            state_in = ST_MUL_P;
         end
         ST_MUL_P: begin
            prod_in  = mul_prod;
            state_in = ST_MUL_I;
         end
         ST_MUL_I: begin
            acc_in   = {prod_ff[pidcb_pkg::PROD_W-1], prod_ff};
            prod_in  = mul_prod;
            state_in = ST_MUL_D;
         end
         ST_MUL_D: begin
            acc_in   = acc_ff + {prod_ff[pidcb_pkg::PROD_W-1], prod_ff};
            prod_in  = mul_prod;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            acc_in   = acc_ff + {prod_ff[pidcb_pkg::PROD_W-1], prod_ff};
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               if ($signed(shifted) > $signed({19'b0, pidcb_pkg::DRIVE_MAX})) begin
                  drive_in = pidcb_pkg::DRIVE_MAX;
                  sat_in   = 1'b1;
               end else if ($signed(shifted) < $signed({{19{1'b1}}, pidcb_pkg::DRIVE_MIN})) begin
                  drive_in = pidcb_pkg::DRIVE_MIN;
                  sat_in   = 1'b1;
               end else begin
                  drive_in = shifted[pidcb_pkg::DRIVE_W-1:0];
                  sat_in   = 1'b0;
               end
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         setpoint_ff   <= pidcb_pkg::SETPOINT_RST;
         gain_p_ff     <= pidcb_pkg::GAIN_P_RST;
         gain_i_ff     <= pidcb_pkg::GAIN_I_RST;
         gain_d_ff     <= pidcb_pkg::GAIN_D_RST;
         limit_ff      <= pidcb_pkg::INT_LIMIT_RST;
         band_ff       <= pidcb_pkg::BAND_RST;
         last_error_ff <= '0;
         error_sum_ff  <= '0;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         setpoint_ff   <= setpoint_in;
         gain_p_ff     <= gain_p_in;
         gain_i_ff     <= gain_i_in;
         gain_d_ff     <= gain_d_in;
         limit_ff      <= limit_in;
         band_ff       <= band_in;
         last_error_ff <= last_error_in;
         error_sum_ff  <= error_sum_in;
      end
      err_ff      <= err_in;
      dt_ff       <= dt_in;
      divisor_ff  <= divisor_in;
      rem_ff      <= rem_in;
      dvd_ff      <= dvd_in;
      cnt_ff      <= cnt_in;
      neg_ff      <= neg_in;
      sum_ff      <= sum_in;
      band_hit_ff <= band_hit_in;
      deriv_ff    <= deriv_in;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      drive_ff    <= drive_in;
      sat_ff      <= sat_in;
   end

endmodule

// File: design/pidcb_checker.sv
// Port-level checker for the PID integral clamp / band reset unit, and its bind.
// Depends on pidcb_pkg and pid_integral_clamp_band_reset_unit_defines.svh.
`include "pid_integral_clamp_band_reset_unit_defines.svh"

module pidcb_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input logic [pidcb_pkg::DRIVE_W-1:0] rsp_drive,
   input logic                          rsp_saturated
);

   logic req_acc;
   assign req_acc = req_valid && !req_stall;

   // a stalled result holds
   `PIDCB_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_drive) && $stable(rsp_saturated), "stalled result changed")

   // one transaction at a time: busy right after acceptance
   `PIDCB_ASSERT_NXT(a_busy_after_acc, clock, reset, req_acc, req_stall, "accepted a second transaction while busy")

   // a result never appears the cycle after acceptance
   `PIDCB_ASSERT_NXT(a_no_early_rsp, clock, reset, req_acc, !$rose(rsp_valid), "result appeared too early")

   // clipping flag only with a rail value
   `PIDCB_ASSERT_IMP(a_sat_rail, clock, reset, rsp_valid && rsp_saturated, rsp_drive == pidcb_pkg::DRIVE_MAX || rsp_drive == pidcb_pkg::DRIVE_MIN, "saturated flag without rail value")

endmodule

bind pid_integral_clamp_band_reset_unit pidcb_checker u_pidcb_checker (.*);
